// ----- hdl/fsma_pkg.sv -----
// shared types and operation codes for the fraction sum and maximum accumulator
package fsma_pkg;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE         = 5'd0;
  localparam op_t OP_LOAD         = 5'd1;
  localparam op_t OP_GCD_IN       = 5'd2;
  localparam op_t OP_GCD_DEN      = 5'd3;
  localparam op_t OP_GCD_SUM      = 5'd4;
  localparam op_t OP_GCD_DIV      = 5'd5;
  localparam op_t OP_GCD_STEP     = 5'd6;
  localparam op_t OP_SAVE_G       = 5'd7;
  localparam op_t OP_DS_NUM       = 5'd8;
  localparam op_t OP_DS_DEN       = 5'd9;
  localparam op_t OP_DS_ACCDEN    = 5'd10;
  localparam op_t OP_DS_SUM       = 5'd11;
  localparam op_t OP_WB_NUM       = 5'd12;
  localparam op_t OP_WB_DEN       = 5'd13;
  localparam op_t OP_WB_DQ        = 5'd14;
  localparam op_t OP_WB_BQ        = 5'd15;
  localparam op_t OP_WB_RN        = 5'd16;
  localparam op_t OP_MUL_P1       = 5'd17;
  localparam op_t OP_ADD_SET      = 5'd18;
  localparam op_t OP_MUL_P2       = 5'd19;
  localparam op_t OP_ADD_ACC      = 5'd20;
  localparam op_t OP_SET_OVF      = 5'd21;
  localparam op_t OP_MUL_RD       = 5'd22;
  localparam op_t OP_SUM_COMMIT   = 5'd23;
  localparam op_t OP_MUL_CA       = 5'd24;
  localparam op_t OP_HOLD_CA      = 5'd25;
  localparam op_t OP_MUL_CB       = 5'd26;
  localparam op_t OP_MAX_COMMIT   = 5'd27;
  localparam op_t OP_FIRST_COMMIT = 5'd28;
  localparam op_t OP_OUT_WRITE    = 5'd29;
  localparam op_t OP_OUT_ZERO     = 5'd30;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic first;
    logic y_zero;
    logic div_done;
    logic s_carry;
  } stat_t;

endpackage

// ----- hdl/fsma_div.sv -----
// shared radix-2 restoring divider, double-width dividend by single-width divisor
module fsma_div #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           wide,
  input  logic [2*W-1:0] dividend,
  input  logic [W-1:0]   divisor,
  output logic [2*W-1:0] quot,
  output logic [W-1:0]   rem,
  output logic           done
);

  localparam int CW = $clog2(2 * W + 1);

  logic [2*W-1:0] q;
  logic [W:0]     r;
  logic [W-1:0]   dv;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [W:0]     r_sh;
  logic           fits;

  assign r_sh = {r[W-1:0], q[2*W-1]};
  assign fits = r_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= wide ? CW'(2 * W) : CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q  <= wide ? dividend : {dividend[W-1:0], {W{1'b0}}};
      r  <= '0;
      dv <= divisor;
    end else if (busy) begin
      r <= fits ? (r_sh - {1'b0, dv}) : r_sh;
      q <= {q[2*W-2:0], fits};
    end
  end

  assign quot = q;
  assign rem  = r[W-1:0];

endmodule

// ----- hdl/fsma_datapath.sv -----
// datapath: fraction registers, gcd registers, multiplier, divider and output beat
module fsma_datapath #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  fsma_pkg::cmd_t cmd,
  output fsma_pkg::stat_t st,
  input  logic [63:0]    s_tdata,
  input  logic           s_tuser,
  output logic [127:0]   m_tdata,
  output logic [1:0]     m_tuser
);

  logic [W-1:0]   num, den, acc_num, acc_den, best_num, best_den;
  logic [W-1:0]   g, bq, dq, y;
  logic [2*W-1:0] x, prod, pa, rn;
  logic [2*W:0]   s;
  logic           first, ovf;

  logic           div_start, div_wide, div_done;
  logic [2*W-1:0] div_a, quot;
  logic [W-1:0]   div_b, rem;
  logic [W-1:0]   mul_a, mul_b;

  fsma_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .wide     (div_wide),
    .dividend (div_a),
    .divisor  (div_b),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  always_comb begin
    div_start = 1'b1;
    div_a     = (2*W)'(num);
    div_b     = g;
    case (cmd.op)
      fsma_pkg::OP_GCD_DIV: begin
        div_a = x;
        div_b = y;
      end
      fsma_pkg::OP_DS_NUM:    div_a = (2*W)'(num);
      fsma_pkg::OP_DS_DEN:    div_a = (2*W)'(den);
      fsma_pkg::OP_DS_ACCDEN: div_a = (2*W)'(acc_den);
      fsma_pkg::OP_DS_SUM:    div_a = s[2*W-1:0];
      default:                div_start = 1'b0;
    endcase
    div_wide = |div_a[2*W-1:W];
  end

  always_comb begin
    case (cmd.op)
      fsma_pkg::OP_MUL_P1: begin
        mul_a = acc_num;
        mul_b = dq;
      end
      fsma_pkg::OP_MUL_P2: begin
        mul_a = num;
        mul_b = bq;
      end
      fsma_pkg::OP_MUL_RD: begin
        mul_a = bq;
        mul_b = dq;
      end
      fsma_pkg::OP_MUL_CA: begin
        mul_a = num;
        mul_b = best_den;
      end
      default: begin
        mul_a = best_num;
        mul_b = den;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num  <= '0;
      acc_den  <= W'(1);
      best_num <= '0;
      best_den <= W'(1);
      ovf      <= 1'b0;
    end else begin
      case (cmd.op)
        fsma_pkg::OP_FIRST_COMMIT: begin
          acc_num  <= num;
          acc_den  <= den;
          best_num <= num;
          best_den <= den;
          ovf      <= 1'b0;
        end
        fsma_pkg::OP_SET_OVF: ovf <= 1'b1;
        fsma_pkg::OP_SUM_COMMIT: begin
          if ((|rn[2*W-1:W]) || (|prod[2*W-1:W])) begin
            ovf <= 1'b1;
          end else begin
            acc_num <= rn[W-1:0];
            acc_den <= prod[W-1:0];
          end
        end
        fsma_pkg::OP_MAX_COMMIT: begin
          if (pa > prod) begin
            best_num <= num;
            best_den <= den;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      fsma_pkg::OP_LOAD: begin
        num   <= s_tdata[W-1:0];
        den   <= s_tdata[32+W-1:32];
        first <= s_tuser;
      end
      fsma_pkg::OP_GCD_IN: begin
        x <= (2*W)'(num);
        y <= den;
      end
      fsma_pkg::OP_GCD_DEN: begin
        x <= (2*W)'(acc_den);
        y <= den;
      end
      fsma_pkg::OP_GCD_SUM: begin
        x <= s[2*W-1:0];
        y <= g;
      end
      fsma_pkg::OP_GCD_STEP: begin
        x <= (2*W)'(y);
        y <= rem;
      end
      fsma_pkg::OP_SAVE_G:  g    <= x[W-1:0];
      fsma_pkg::OP_WB_NUM:  num  <= quot[W-1:0];
      fsma_pkg::OP_WB_DEN:  den  <= quot[W-1:0];
      fsma_pkg::OP_WB_DQ:   dq   <= quot[W-1:0];
      fsma_pkg::OP_WB_BQ:   bq   <= quot[W-1:0];
      fsma_pkg::OP_WB_RN:   rn   <= quot;
      fsma_pkg::OP_MUL_P1,
      fsma_pkg::OP_MUL_P2,
      fsma_pkg::OP_MUL_RD,
      fsma_pkg::OP_MUL_CA,
      fsma_pkg::OP_MUL_CB:  prod <= mul_a * mul_b;
      fsma_pkg::OP_ADD_SET: s    <= (2*W+1)'(prod);
      fsma_pkg::OP_ADD_ACC: s    <= s + (2*W+1)'(prod);
      fsma_pkg::OP_HOLD_CA: pa   <= prod;
      fsma_pkg::OP_OUT_WRITE,
      fsma_pkg::OP_OUT_ZERO: begin
        m_tdata <= {32'(best_den), 32'(best_num), 32'(acc_den), 32'(acc_num)};
        m_tuser <= {cmd.op == fsma_pkg::OP_OUT_ZERO, ovf};
      end
      default: ;
    endcase
  end

  assign st.den_zero = den == '0;
  assign st.first    = first;
  assign st.y_zero   = y == '0;
  assign st.div_done = div_done;
  assign st.s_carry  = s[2*W];

endmodule

// ----- hdl/fsma_ctrl.sv -----
// controller: sequences gcd loops, divisions, products and the stream handshake
module fsma_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  fsma_pkg::stat_t st,
  output fsma_pkg::cmd_t  cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_GCD  = 5'd2;
  localparam logic [4:0] S_GCDW = 5'd3;
  localparam logic [4:0] S_DIVW = 5'd4;
  localparam logic [4:0] S_DNUM = 5'd5;
  localparam logic [4:0] S_DDEN = 5'd6;
  localparam logic [4:0] S_FORK = 5'd7;
  localparam logic [4:0] S_DBQ  = 5'd8;
  localparam logic [4:0] S_DDQ  = 5'd9;
  localparam logic [4:0] S_M1   = 5'd10;
  localparam logic [4:0] S_A1   = 5'd11;
  localparam logic [4:0] S_M2   = 5'd12;
  localparam logic [4:0] S_A2   = 5'd13;
  localparam logic [4:0] S_CRY  = 5'd14;
  localparam logic [4:0] S_DRN  = 5'd15;
  localparam logic [4:0] S_DT   = 5'd16;
  localparam logic [4:0] S_MRD  = 5'd17;
  localparam logic [4:0] S_SCOM = 5'd18;
  localparam logic [4:0] S_MA   = 5'd19;
  localparam logic [4:0] S_HA   = 5'd20;
  localparam logic [4:0] S_MB   = 5'd21;
  localparam logic [4:0] S_MCOM = 5'd22;
  localparam logic [4:0] S_OUT  = 5'd23;
  localparam logic [4:0] S_OUTZ = 5'd24;

  localparam logic [1:0] P_IN  = 2'd0;
  localparam logic [1:0] P_DEN = 2'd1;
  localparam logic [1:0] P_SUM = 2'd2;

  logic [4:0]      state, state_next, ret, ret_next;
  logic [1:0]      phase, phase_next;
  fsma_pkg::op_t   wb, wb_next;
  logic            out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    phase_next = phase;
    wb_next    = wb;
    cmd.op     = fsma_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = fsma_pkg::OP_LOAD;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (st.den_zero) begin
          state_next = S_OUTZ;
        end else begin
          cmd.op     = fsma_pkg::OP_GCD_IN;
          phase_next = P_IN;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (st.y_zero) begin
          cmd.op = fsma_pkg::OP_SAVE_G;
          case (phase)
            P_IN:    state_next = S_DNUM;
            P_DEN:   state_next = S_DBQ;
            default: state_next = S_DRN;
          endcase
        end else begin
          cmd.op     = fsma_pkg::OP_GCD_DIV;
          state_next = S_GCDW;
        end
      end
      S_GCDW: begin
        if (st.div_done) begin
          cmd.op     = fsma_pkg::OP_GCD_STEP;
          state_next = S_GCD;
        end
      end
      S_DIVW: begin
        if (st.div_done) begin
          cmd.op     = wb;
          state_next = ret;
        end
      end
      S_DNUM: begin
        cmd.op     = fsma_pkg::OP_DS_NUM;
        wb_next    = fsma_pkg::OP_WB_NUM;
        ret_next   = S_DDEN;
        state_next = S_DIVW;
      end
      S_DDEN: begin
        cmd.op     = fsma_pkg::OP_DS_DEN;
        wb_next    = fsma_pkg::OP_WB_DEN;
        ret_next   = S_FORK;
        state_next = S_DIVW;
      end
      S_FORK: begin
        if (st.first) begin
          cmd.op     = fsma_pkg::OP_FIRST_COMMIT;
          state_next = S_OUT;
        end else begin
          cmd.op     = fsma_pkg::OP_GCD_DEN;
          phase_next = P_DEN;
          state_next = S_GCD;
        end
      end
      S_DBQ: begin
        cmd.op     = fsma_pkg::OP_DS_ACCDEN;
        wb_next    = fsma_pkg::OP_WB_BQ;
        ret_next   = S_DDQ;
        state_next = S_DIVW;
      end
      S_DDQ: begin
        cmd.op     = fsma_pkg::OP_DS_DEN;
        wb_next    = fsma_pkg::OP_WB_DQ;
        ret_next   = S_M1;
        state_next = S_DIVW;
      end
      S_M1: begin
        cmd.op     = fsma_pkg::OP_MUL_P1;
        state_next = S_A1;
      end
      S_A1: begin
        cmd.op     = fsma_pkg::OP_ADD_SET;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.op     = fsma_pkg::OP_MUL_P2;
        state_next = S_A2;
      end
      S_A2: begin
        cmd.op     = fsma_pkg::OP_ADD_ACC;
        state_next = S_CRY;
      end
      S_CRY: begin
        if (st.s_carry) begin
          cmd.op     = fsma_pkg::OP_SET_OVF;
          state_next = S_MA;
        end else begin
          cmd.op     = fsma_pkg::OP_GCD_SUM;
          phase_next = P_SUM;
          state_next = S_GCD;
        end
      end
      S_DRN: begin
        cmd.op     = fsma_pkg::OP_DS_SUM;
        wb_next    = fsma_pkg::OP_WB_RN;
        ret_next   = S_DT;
        state_next = S_DIVW;
      end
      S_DT: begin
        cmd.op     = fsma_pkg::OP_DS_DEN;
        wb_next    = fsma_pkg::OP_WB_DQ;
        ret_next   = S_MRD;
        state_next = S_DIVW;
      end
      S_MRD: begin
        cmd.op     = fsma_pkg::OP_MUL_RD;
        state_next = S_SCOM;
      end
      S_SCOM: begin
        cmd.op     = fsma_pkg::OP_SUM_COMMIT;
        state_next = S_MA;
      end
      S_MA: begin
        cmd.op     = fsma_pkg::OP_MUL_CA;
        state_next = S_HA;
      end
      S_HA: begin
        cmd.op     = fsma_pkg::OP_HOLD_CA;
        state_next = S_MB;
      end
      S_MB: begin
        cmd.op     = fsma_pkg::OP_MUL_CB;
        state_next = S_MCOM;
      end
      S_MCOM: begin
        cmd.op     = fsma_pkg::OP_MAX_COMMIT;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op     = fsma_pkg::OP_OUT_WRITE;
          state_next = S_IDLE;
        end
      end
      S_OUTZ: begin
        if (out_free) begin
          cmd.op     = fsma_pkg::OP_OUT_ZERO;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      phase    <= P_IN;
      wb       <= fsma_pkg::OP_NONE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      phase <= phase_next;
      wb    <= wb_next;
      if (cmd.op == fsma_pkg::OP_OUT_WRITE || cmd.op == fsma_pkg::OP_OUT_ZERO) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == fsma_pkg::OP_OUT_WRITE || cmd.op == fsma_pkg::OP_OUT_ZERO) |-> out_free)
    else $error("result loaded over a pending beat");

  // divider completion is only seen while waiting for it
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> (state == S_DIVW || state == S_GCDW))
    else $error("divider finished outside a wait state");

  // an accepted beat always goes to the zero denominator check
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == S_CHK)
    else $error("accepted beat not followed by check");

endmodule

// ----- hdl/fraction_sum_max_accumulator.sv -----
// top level of the fraction sum and maximum accumulator
// Each input beat carries one unsigned fraction and a flag that starts a new set; the block
// keeps the running sum and running maximum in lowest terms and returns one beat per input
// beat. Items are handled one at a time. The time per item is set by the shared radix-2
// divider, which runs longer on a double-width dividend: the input gcd, the denominator gcd
// and the sum gcd each need one division per Euclid step (at most about 1.44*WIDTH steps),
// plus six plain divisions, the products and the bookkeeping. A zero denominator is answered
// without any division and leaves the state untouched. The next beat is taken while a
// finished result still waits.
module fraction_sum_max_accumulator #(
  parameter int WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // numerator [31:0], denominator [63:32]
  input  logic         s_tuser,   // first_item
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // sum_numerator, sum_denominator, max_numerator, max_denominator
  output logic [1:0]   m_tuser    // overflow, zero_denominator
);

  // command and status between the sequencer and the arithmetic
  fsma_pkg::cmd_t  cmd;
  fsma_pkg::stat_t st;

  fsma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  fsma_datapath #(.W(WIDTH)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .st      (st),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ----- verif/tb_fraction_sum_max_accumulator.sv -----
// self-checking testbench for the fraction sum and maximum accumulator
module tb_fraction_sum_max_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH = 32;
  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        first;
  } frac_in_t;

  typedef struct packed {
    logic [31:0] sum_num;
    logic [31:0] sum_den;
    logic [31:0] max_num;
    logic [31:0] max_den;
    logic        ovf;
    logic        zden;
  } frac_out_t;

  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [1:0] m_tuser;

  fraction_sum_max_accumulator #(.WIDTH(WIDTH)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state, mirrors the block's accumulator registers
  logic [63:0] acc_n = 64'd0, acc_d = 64'd1, top_n = 64'd0, top_d = 64'd1;
  logic        ovf_sticky = 1'b0;

  frac_in_t  pending_fracs[$];
  frac_out_t expected_sums[$];
  phase_e    phase = PH_FREE;
  bit        hold_src = 1'b0;
  int        errors = 0;
  int        beats_in = 0, beats_out = 0, zero_den_seen = 0, ovf_seen_cnt = 0;
  int        beats_seen = 0;
  longint unsigned cycles = 0;

  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // fold one fraction into the running sum and maximum, return the beat expected
  function automatic frac_out_t accumulate_fraction(frac_in_t it);
    logic [63:0] mask, n, d, g, gd, bq, dq, p1, p2, s, g2, rn, rd;
    frac_out_t r;
    mask = (64'd1 << WIDTH) - 1;
    n = it.num & mask;
    d = it.den & mask;
    r.zden = (d == 0);
    if (d != 0) begin
      g = euclid_gcd(n, d);
      n = n / g;
      d = d / g;
      if (it.first) begin
        acc_n = n; acc_d = d; top_n = n; top_d = d; ovf_sticky = 1'b0;
      end else begin
        gd = euclid_gcd(acc_d, d);
        bq = acc_d / gd;
        dq = d / gd;
        p1 = acc_n * dq;
        p2 = n * bq;
        s = p1 + p2;
        if (s < p1) begin
          ovf_sticky = 1'b1;
        end else begin
          g2 = euclid_gcd(s, gd);
          rn = s / g2;
          rd = bq * (d / g2);
          if (rn > mask || rd > mask) begin
            ovf_sticky = 1'b1;
          end else begin
            acc_n = rn; acc_d = rd;
          end
        end
        if (n * top_d > top_n * d) begin
          top_n = n; top_d = d;
        end
      end
    end
    r.sum_num = acc_n[31:0];
    r.sum_den = acc_d[31:0];
    r.max_num = top_n[31:0];
    r.max_den = top_d[31:0];
    r.ovf = ovf_sticky;
    return r;
  endfunction

  function automatic logic [31:0] rand_field(int k);
    case (k)
      0: return $urandom_range(0, 15);
      1: return $urandom_range(1, 1000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 7);
      3: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic push(logic [31:0] n, logic [31:0] d, logic f);
    frac_in_t it;
    it.num = n; it.den = d; it.first = f;
    pending_fracs.push_back(it);
  endtask

  // driver: presents beats at the falling edge, holds a beat until it is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || beats_in != beats_seen) begin
      beats_seen = beats_in;
      if (pending_fracs.size() > 0 && !hold_src &&
          !((phase == PH_SRC_IDLE || phase == PH_BOTH) && $urandom_range(0, 99) < 71)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {pending_fracs[0].den, pending_fracs[0].num};
        s_tuser  <= pending_fracs[0].first;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !rst && !((phase == PH_SNK_STALL || phase == PH_BOTH) &&
                          $urandom_range(0, 99) < 71);
  end

  // monitor: input acceptance feeds the predictor, output beats are checked
  always @(posedge clk) begin
    frac_in_t  it;
    frac_out_t got, exp_beat;
    cycles <= cycles + 1;
    if (!rst && s_tvalid && s_tready) begin
      it = pending_fracs.pop_front();
      expected_sums.push_back(accumulate_fraction(it));
      beats_in <= beats_in + 1;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
             m_tuser[0], m_tuser[1]};
      beats_out <= beats_out + 1;
      if (got.zden) zero_den_seen <= zero_den_seen + 1;
      if (got.ovf) ovf_seen_cnt <= ovf_seen_cnt + 1;
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors <= errors + 1;
      end else begin
        exp_beat = expected_sums.pop_front();
        if (got !== exp_beat) begin
          $display("%0t: mismatch exp sum %0d/%0d max %0d/%0d ovf %b zd %b", $time,
                   exp_beat.sum_num, exp_beat.sum_den, exp_beat.max_num, exp_beat.max_den,
                   exp_beat.ovf, exp_beat.zden);
          $display("%0t:          got sum %0d/%0d max %0d/%0d ovf %b zd %b", $time,
                   got.sum_num, got.sum_den, got.max_num, got.max_den, got.ovf, got.zden);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (pending_fracs.size() > 0 || expected_sums.size() > 0 || s_tvalid)
      @(posedge clk);
  endtask

  initial begin
    int k, n_rand;
    logic [31:0] base;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: no set started, extremes, zero denominator, ties, overflow
    push(32'd1, 32'd2, 1'b0);
    push(32'd0, 32'd5, 1'b0);
    push(32'd7, 32'd0, 1'b1);
    push(32'd0, 32'd0, 1'b0);
    push(32'd6, 32'd4, 1'b1);
    push(32'd3, 32'd2, 1'b0);
    push(32'd9, 32'd6, 1'b0);
    push(32'd0, 32'd1, 1'b0);
    push(32'hFFFF_FFFF, 32'd1, 1'b1);
    push(32'hFFFF_FFFF, 32'd1, 1'b0);
    push(32'd1, 32'hFFFF_FFFF, 1'b0);
    push(32'd1, 32'hFFFF_FFFE, 1'b1);
    push(32'd1, 32'hFFFF_FFFD, 1'b0);
    push(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
    push(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    push(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    push(32'd0, 32'hFFFF_FFFF, 1'b1);
    push(32'd10, 32'd15, 1'b0);
    drain();

    // random: sets of small fractions, with wide values and zero denominators mixed in
    n_rand = 2000;
    for (int ph = 0; ph < 4; ph++) begin
      phase = phase_e'(ph);
      for (int i = 0; i < n_rand / 4; i++) begin
        k = $urandom_range(0, 99);
        base = (k < 70) ? rand_field($urandom_range(0, 1)) : rand_field($urandom_range(0, 4));
        push(base, (k < 4) ? 32'd0 : (k < 70 ? rand_field(1) : rand_field($urandom_range(0, 4))),
             $urandom_range(0, 9) == 0);
        if (i == n_rand / 8) begin
          drain();
          hold_src = 1'b1;
          wait (expected_sums.size() == 0);
          hold_src = 1'b0;
        end
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("%0d fractions sent, %0d results checked, %0d zero-denominator, %0d overflow",
             beats_in, beats_out, zero_den_seen, ovf_seen_cnt);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
